FILE: rtl/sdspi_pkg.sv
// sdspi_pkg: shared types, codes and crc helpers for the sd spi block read engine
// no dependencies; imported by the engine and its checker

package sdspi_pkg;

	localparam int DATA_LEN_W = 10;
	localparam int TRIES_W    = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DATA_LEN       = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_TRIES = 1'd1;

	localparam logic [DATA_LEN_W-1:0] DATA_LEN_RST = 10'd512;
	localparam logic [TRIES_W-1:0]    TRIES_RST    = 16'h8000;

	localparam logic [7:0] BYTE_IDLE  = 8'hff;
	localparam logic [7:0] BYTE_TOKEN = 8'hfe;
	localparam logic [1:0] CMD_PREFIX = 2'b01;

	localparam logic [2:0] FRAME_FIRST = 3'd0;
	localparam logic [2:0] FRAME_CMD   = 3'd1;
	localparam logic [2:0] FRAME_ARG3  = 3'd2;
	localparam logic [2:0] FRAME_ARG2  = 3'd3;
	localparam logic [2:0] FRAME_ARG1  = 3'd4;
	localparam logic [2:0] FRAME_ARG0  = 3'd5;
	localparam logic [2:0] FRAME_LAST  = 3'd6;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_R1     = 3'd1,
		PH_TOKEN  = 3'd2,
		PH_DATA   = 3'd3,
		PH_CRC_HI = 3'd4,
		PH_CRC_LO = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_TX     = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_CMD   = 2'd1,
		STAT_TOKEN = 2'd2,
		STAT_CRC   = 2'd3
	} status_t;

	typedef enum logic {
		MODE_START = 1'b0,
		MODE_RX    = 1'b1
	} mode_t;

	typedef struct packed {
		logic        mode;
		logic [5:0]  cmd_index;
		logic [31:0] cmd_arg;
		logic [7:0]  rx_byte;
	} req_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic [1:0] status;
		logic       last;
	} rsp_t;

	// crc7 over one byte, msb first, kept left aligned (bit 0 stays clear)
	function automatic logic [7:0] crc7_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = c ^ 8'h09;
			end
			c = {c[6:0], 1'b0};
		end
		return c;
	endfunction

	// crc16 ccitt (0x1021) over one byte, msb first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ 16'h1021;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: rtl/sd_spi_block_read_engine.sv
// sd_spi_block_read_engine: sd card spi-mode single block read sequencer
// depends on sdspi_pkg (types, codes, crc7/crc16 byte functions)
//
// usage:
//   req channel (req_valid/req_stall/req): one beat is either a start
//   (mode 0: cmd_index, cmd_arg) or one byte received from the card (mode 1).
//   rsp channel (rsp_valid/rsp_stall/rsp): transmit bytes, data bytes and a
//   final status beat, in order.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 data_len,
//   index 1 response_tries; cfg_ready is always high, write only when idle.
// data path: a beat is taken into the input register, and its first result
//   beat is then registered in the output register when that can take it.
// throughput: received bytes go through at one per cycle when not stalled;
//   a start holds the engine for its seven frame bytes, one beat each, as the
//   single output register moves one beat per cycle and crc7 grows bytewise.
// a start during a transfer drops it and sends a new frame.
// reset: phase idle, both pipeline registers empty, data_len 512,
//   response_tries 32768.
// receiver stall: the output register holds its beat, the input register
//   holds its item and req_stall rises once it is occupied.

module sd_spi_block_read_engine
	import sdspi_pkg::*;
#(
	parameter int MAX_BLOCK = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration
	logic [DATA_LEN_W-1:0] data_len_q;
	logic [TRIES_W-1:0]    tries_q;

	// input register
	logic valid_s1;
	req_t req_s1;

	// engine state
	phase_t                phase_q, phase_d;
	logic [TRIES_W-1:0]    wait_q, wait_d;
	logic [DATA_LEN_W-1:0] left_q, left_d;
	logic [15:0]           crc_q, crc_d;
	logic                  mism_q, mism_d;
	logic [2:0]            idx_q;
	logic [7:0]            crc7_q;

	// output register
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic                  out_ready;
	logic                  go;
	logic                  is_start;
	logic                  consume;
	logic                  accept;
	logic                  emit;
	rsp_t                  beat;
	logic [7:0]            frame_byte;
	logic [TRIES_W-1:0]    tries_eff;
	logic [DATA_LEN_W-1:0] len_sat;
	logic [7:0]            rx;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_len_q <= DATA_LEN_RST;
			tries_q    <= TRIES_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DATA_LEN:       data_len_q <= cfg_data[DATA_LEN_W-1:0];
				REG_RESPONSE_TRIES: tries_q    <= cfg_data[TRIES_W-1:0];
				default: ;
			endcase
		end
	end

	// zero tries acts as one, long lengths clip to the block size
	assign tries_eff = (tries_q == '0) ? TRIES_W'(1) : tries_q;
	assign len_sat   = (32'(data_len_q) > MAX_BLOCK) ? DATA_LEN_W'(MAX_BLOCK) : data_len_q;

	// handshake: s1 advances whenever the output register can take a beat; a start frees s1 only with its last frame byte
	assign out_ready = !rsp_valid_q || !rsp_stall;
	assign is_start  = (req_s1.mode == MODE_START);
	assign go        = valid_s1 && out_ready;
	assign consume   = go && (!is_start || idx_q == FRAME_LAST);
	assign req_stall = valid_s1 && !consume;
	assign accept    = req_valid && !req_stall;
	assign rx        = req_s1.rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	// frame byte for the current position of a start
	always_comb begin
		case (idx_q)
			FRAME_FIRST: frame_byte = BYTE_IDLE;
			FRAME_CMD:   frame_byte = {CMD_PREFIX, req_s1.cmd_index};
			FRAME_ARG3:  frame_byte = req_s1.cmd_arg[31:24];
			FRAME_ARG2:  frame_byte = req_s1.cmd_arg[23:16];
			FRAME_ARG1:  frame_byte = req_s1.cmd_arg[15:8];
			FRAME_ARG0:  frame_byte = req_s1.cmd_arg[7:0];
			default:     frame_byte = {crc7_q[7:1], 1'b1};
		endcase
	end

	// frame position and running crc7
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= FRAME_FIRST;
		end else if (go && is_start) begin
			idx_q <= (idx_q == FRAME_LAST) ? FRAME_FIRST : idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go && is_start) begin
			if (idx_q == FRAME_FIRST) begin
				crc7_q <= 8'h00;
			end else begin
				crc7_q <= crc7_byte(crc7_q, frame_byte);
			end
		end
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		wait_d  = wait_q;
		left_d  = left_q;
		crc_d   = crc_q;
		mism_d  = mism_q;
		if (is_start) begin
			phase_d = PH_R1;
			wait_d  = tries_eff;
			left_d  = '0;
			crc_d   = '0;
			mism_d  = 1'b0;
		end else begin
			case (phase_q)
				PH_R1, PH_TOKEN: begin
					if (rx == BYTE_IDLE) begin
						if (wait_q <= TRIES_W'(1)) begin
							phase_d = PH_IDLE;
						end else begin
							wait_d = wait_q - TRIES_W'(1);
						end
					end else if (phase_q == PH_R1) begin
						if (rx != 8'h00) begin
							phase_d = PH_IDLE;
						end else begin
							phase_d = PH_TOKEN;
							wait_d  = tries_eff;
						end
					end else if (rx != BYTE_TOKEN) begin
						phase_d = PH_IDLE;
					end else begin
						crc_d   = '0;
						mism_d  = 1'b0;
						left_d  = len_sat;
						phase_d = (len_sat == '0) ? PH_CRC_HI : PH_DATA;
					end
				end
				PH_DATA: begin
					crc_d  = crc16_byte(crc_q, rx);
					left_d = (left_q != '0) ? left_q - DATA_LEN_W'(1) : '0;
					if (left_q <= DATA_LEN_W'(1)) begin
						phase_d = PH_CRC_HI;
					end
				end
				PH_CRC_HI: begin
					mism_d  = (rx != crc_q[15:8]);
					phase_d = PH_CRC_LO;
				end
				PH_CRC_LO: begin
					phase_d = PH_IDLE;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// outputs
	always_comb begin
		emit          = 1'b0;
		beat.kind     = KIND_TX;
		beat.out_byte = 8'h00;
		beat.status   = STAT_OK;
		beat.last     = 1'b0;
		if (is_start) begin
			emit          = 1'b1;
			beat.out_byte = frame_byte;
			beat.last     = (idx_q == FRAME_LAST);
		end else begin
			case (phase_q)
				PH_R1, PH_TOKEN: begin
					beat.kind = KIND_STATUS;
					beat.last = 1'b1;
					beat.out_byte = rx;
					beat.status = (phase_q == PH_R1) ? STAT_CMD : STAT_TOKEN;
					if (rx == BYTE_IDLE) begin
						emit = (wait_q <= TRIES_W'(1));
					end else if (phase_q == PH_R1) begin
						emit = (rx != 8'h00);
					end else begin
						emit = (rx != BYTE_TOKEN);
					end
				end
				PH_DATA: begin
					emit          = 1'b1;
					beat.kind     = KIND_DATA;
					beat.out_byte = rx;
				end
				PH_CRC_LO: begin
					emit        = 1'b1;
					beat.kind   = KIND_STATUS;
					beat.last   = 1'b1;
					beat.status = (mism_q || rx != crc_q[7:0]) ? STAT_CRC : STAT_OK;
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			wait_q  <= '0;
			left_q  <= '0;
			crc_q   <= '0;
			mism_q  <= 1'b0;
		end else if (consume) begin
			phase_q <= phase_d;
			wait_q  <= wait_d;
			left_q  <= left_d;
			crc_q   <= crc_d;
			mism_q  <= mism_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_ready) begin
			rsp_valid_q <= go && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			rsp_q <= beat;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: rtl/sdspi_chk.sv
// sdspi_chk: port-level checks for the sd spi block read engine, plus its bind
// depends on sdspi_pkg and on the sd_spi_block_read_engine port list

module sdspi_chk
	import sdspi_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled rsp beat changed");

	// every status beat closes its transfer
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_STATUS |-> rsp.last)
		else $error("status beat without last");

	// data bytes never carry last and data beats carry no status
	a_data_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_DATA |-> !rsp.last && rsp.status == STAT_OK)
		else $error("data beat with last or status");

	// closing frame byte carries the end bit
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_TX && rsp.last |-> rsp.out_byte[0])
		else $error("frame crc byte missing end bit");

endmodule

bind sd_spi_block_read_engine sdspi_chk u_sdspi_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
